@@ sv/bfpa_pkg.sv @@
// ---------------------------------------------------------------------------
// bfpa_pkg: shared types for the best-fit partition allocator
// Request and result formats, request kinds and controller states.
// ---------------------------------------------------------------------------
package bfpa_pkg;

	localparam int VAL_W = 16;
	localparam int BIDX_W = 4;
	localparam int CNT_W = 5;
	localparam logic [CNT_W-1:0] CNT_RESET = 5'd16;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_ALLOC = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [BIDX_W-1:0] block_index;
		logic [VAL_W-1:0]  size_value;
	} req_t;

	typedef struct packed {
		logic              allocated;
		logic [BIDX_W-1:0] chosen_block;
		logic [VAL_W-1:0]  leftover_size;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_HOLD
	} state_t;

endpackage

@@ sv/bfpa_cell.sv @@
// ---------------------------------------------------------------------------
// bfpa_cell: one partition slot of the allocator chain
// Holds one partition size and its occupied mark, compares the passing
// search packet against them and forwards the updated packet.
// ---------------------------------------------------------------------------
module bfpa_cell #(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_BITS = 16,
	parameter int CELL_IDX = 0
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  logic                                                 active,
	input  logic [2+SIZE_BITS-1:0]                               wr,
	input  logic [2+$clog2(NUM_BLOCKS)+SIZE_BITS+bfpa_pkg::VAL_W-1:0] pkt_in,
	output logic [2+$clog2(NUM_BLOCKS)+SIZE_BITS+bfpa_pkg::VAL_W-1:0] pkt_out
);
	import bfpa_pkg::*;

	localparam int IDX_W = $clog2(NUM_BLOCKS);
	localparam int CMP_W = (SIZE_BITS > VAL_W) ? SIZE_BITS : VAL_W;

	typedef struct packed {
		logic                 valid;
		logic                 found;
		logic [IDX_W-1:0]     idx;
		logic [SIZE_BITS-1:0] size;
		logic [VAL_W-1:0]     req;
	} pkt_t;

	typedef struct packed {
		logic                 en;
		logic                 taken;
		logic [SIZE_BITS-1:0] size;
	} wr_t;

	pkt_t                 pin;
	pkt_t                 pkt_q;
	wr_t                  w;
	logic [SIZE_BITS-1:0] size_q;
	logic                 taken_q;
	logic                 pick;

	assign pin = pkt_t'(pkt_in);
	assign w = wr_t'(wr);
	assign pkt_out = pkt_q;

	assign pick = pin.valid && active && !taken_q &&
		(CMP_W'(size_q) >= CMP_W'(pin.req)) &&
		(!pin.found || (pin.size >= size_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= 1'b0;
		end else if (w.en) begin
			taken_q <= w.taken;
		end
	end

	always_ff @(posedge clk) begin
		if (w.en) begin
			size_q <= w.size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_q <= '0;
		end else begin
			pkt_q.valid <= pin.valid;
			pkt_q.req <= pin.req;
			if (pick) begin
				pkt_q.found <= 1'b1;
				pkt_q.idx <= IDX_W'(CELL_IDX);
				pkt_q.size <= size_q;
			end else begin
				pkt_q.found <= pin.found;
				pkt_q.idx <= pin.idx;
				pkt_q.size <= pin.size;
			end
		end
	end

endmodule

@@ sv/best_fit_partition_allocator.sv @@
// ---------------------------------------------------------------------------
// best_fit_partition_allocator: best-fit fixed-partition allocator
//
//   channel   ports                          direction
//   request   in_valid, in_stall, in_data    into the block
//   result    out_valid, out_stall, out_data out of the block
//   config    cfg_we, cfg_data               into the block
//
// A load request produces no result.
// An allocation request sends one search packet down the chain of partition
// cells, one cell per cycle.
// Reset clears all occupied marks and sets the partition count to 16.
// A result held by out_stall blocks the next allocation at its last step.
// ---------------------------------------------------------------------------
module best_fit_partition_allocator #(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  bfpa_pkg::req_t                         in_data,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output bfpa_pkg::rsp_t                         out_data,
	input  logic                                   cfg_we,
	input  logic [bfpa_pkg::CNT_W-1:0]             cfg_data
);
	import bfpa_pkg::*;

	localparam int IDX_W = $clog2(NUM_BLOCKS);
	localparam int CMP_W = (SIZE_BITS > VAL_W) ? SIZE_BITS : VAL_W;

	typedef struct packed {
		logic                 valid;
		logic                 found;
		logic [IDX_W-1:0]     idx;
		logic [SIZE_BITS-1:0] size;
		logic [VAL_W-1:0]     req;
	} pkt_t;

	typedef struct packed {
		logic                 en;
		logic                 taken;
		logic [SIZE_BITS-1:0] size;
	} wr_t;

	state_t               state_q;
	state_t               state_d;
	logic [CNT_W-1:0]     blk_cnt_q;
	logic                 start_q;
	logic [VAL_W-1:0]     req_q;
	pkt_t                 fin_q;
	logic                 out_valid_q;
	rsp_t                 out_q;

	pkt_t                 pkt [NUM_BLOCKS+1];
	wr_t                  wr [NUM_BLOCKS];
	logic [NUM_BLOCKS-1:0] active;
	logic [NUM_BLOCKS-1:0] commit_hit;
	logic [NUM_BLOCKS:0]   pkt_valid;

	logic                 accept;
	logic                 load_go;
	logic                 alloc_go;
	logic                 out_free;
	logic                 commit_go;
	pkt_t                 src;
	logic [CMP_W-1:0]     diff;
	logic [SIZE_BITS-1:0] new_size;
	rsp_t                 rsp;

	assign accept = in_valid && !in_stall;
	assign load_go = accept && (in_data.kind == KIND_LOAD);
	assign alloc_go = accept && (in_data.kind == KIND_ALLOC);
	assign out_free = !out_valid_q || !out_stall;

	assign pkt[0].valid = start_q;
	assign pkt[0].found = 1'b0;
	assign pkt[0].idx = '0;
	assign pkt[0].size = '0;
	assign pkt[0].req = req_q;

	assign src = (state_q == ST_SCAN) ? pkt[NUM_BLOCKS] : fin_q;
	assign diff = CMP_W'(src.size) - CMP_W'(src.req);
	assign new_size = diff[SIZE_BITS-1:0];

	always_comb begin
		rsp.allocated = src.found;
		rsp.chosen_block = src.found ? BIDX_W'(src.idx) : '0;
		rsp.leftover_size = src.found ? VAL_W'(CMP_W'(new_size)) : '0;
	end

	generate
		for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
			assign active[i] = (32'(blk_cnt_q) > 32'(i));
			assign commit_hit[i] = commit_go && src.found && (src.idx == IDX_W'(i));
			assign pkt_valid[i] = pkt[i].valid;

			always_comb begin
				wr[i].en = commit_hit[i] ||
					(load_go && (32'(in_data.block_index) == 32'(i)));
				wr[i].taken = commit_hit[i];
				wr[i].size = commit_hit[i] ? new_size : SIZE_BITS'(in_data.size_value);
			end

			bfpa_cell #(
				.NUM_BLOCKS(NUM_BLOCKS),
				.SIZE_BITS(SIZE_BITS),
				.CELL_IDX(i)
			) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.active(active[i]),
				.wr(wr[i]),
				.pkt_in(pkt[i]),
				.pkt_out(pkt[i+1])
			);
		end
	endgenerate

	assign pkt_valid[NUM_BLOCKS] = pkt[NUM_BLOCKS].valid;

	always_comb begin
		state_d = state_q;
		in_stall = 1'b1;
		commit_go = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (alloc_go) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (pkt[NUM_BLOCKS].valid) begin
					if (out_free) begin
						commit_go = 1'b1;
						state_d = ST_IDLE;
					end else begin
						state_d = ST_HOLD;
					end
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					commit_go = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			blk_cnt_q <= CNT_RESET;
			start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			start_q <= alloc_go;
			if (cfg_we) begin
				blk_cnt_q <= cfg_data;
			end
			if (commit_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (alloc_go) begin
			req_q <= in_data.size_value;
		end
		if (pkt[NUM_BLOCKS].valid) begin
			fin_q <= pkt[NUM_BLOCKS];
		end
		if (commit_go) begin
			out_q <= rsp;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	a_one_packet: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(pkt_valid))
		else $error("more than one search packet in the chain");

	a_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pkt[NUM_BLOCKS].valid |-> state_q == ST_SCAN)
		else $error("search finished outside the scan state");

	a_one_commit: assert property (@(posedge clk) disable iff (!arst_n)
		commit_go |-> $onehot0(commit_hit) && state_q != ST_IDLE)
		else $error("bad partition commit");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) && !out_q.allocated |->
			out_q.chosen_block == '0 && out_q.leftover_size == '0)
		else $error("unallocated result carries nonzero fields");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !accept)
		else $error("request accepted while busy");

endmodule
